@@ src/pipmz_pkg.sv @@
// ----------------------------------------------------------------------------
// pipmz_pkg
// Types and codes shared by the polygon zone test block.
// ----------------------------------------------------------------------------
package pipmz_pkg;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OP_WRITE_VERTEX = 2'd0,
      OP_SET_COUNT    = 2'd1,
      OP_QUERY        = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic CSR_ROOM_COUNT     = 1'b0;
   localparam logic CSR_INVALID_MARKER = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic [3:0]         poly_index;
      logic [4:0]         vertex_index;
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
   } req_type;

   typedef struct packed {
      logic               inside_map;
      logic [7:0]         room_mask;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   // operands for one edge product pair
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_req_type;

endpackage

@@ src/pipmz_mul.sv @@
// ----------------------------------------------------------------------------
// pipmz_mul
// Shared registered signed multiplier, 33 by 33 bits, one product a cycle.
// ----------------------------------------------------------------------------
module pipmz_mul (
   input  logic                  clock,
   input  pipmz_pkg::mul_req_type mul_req,
   output logic signed [65:0]    product
);
   import pipmz_pkg::*;

   logic signed [65:0] product_ff;

   // one product, registered; operands sign extended to the full width
   always_ff @(posedge clock) begin
      product_ff <= 66'(mul_req.a) * 66'(mul_req.b);
   end

   assign product = product_ff;
endmodule

@@ src/point_in_polygon_map_zones.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_map_zones
// Even-odd point in polygon test against box, outline and rooms.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// req_    | in        | start high, busy low
// rsp_    | out       | rsp_valid strobe, one cycle
// csr_    | in        | csr_valid and csr_ready
//
// load and ignored items hold busy through S_POLY only, after acceptance
// a query walks each polygon from S_POLY: one with fewer than 3 vertices goes
// to S_NEXT, else each edge is read (S_RD_J, S_RD_I) and checked (S_CHECK);
// an edge across the query row adds S_MUL2, S_WAIT1, S_CMP; S_DONE ends it
// rsp_valid rises in the same cycle busy falls; results cannot be stalled
// reset clears sizes, state and csr registers; vertex memory holds no reset
// ----------------------------------------------------------------------------
module point_in_polygon_map_zones #(
   parameter int MAX_VERTS = 16,
   parameter int MAX_ROOMS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pipmz_pkg::req_type  req_item,
   output logic                rsp_valid,
   output pipmz_pkg::rsp_type  rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [31:0]         csr_data
);
   import pipmz_pkg::*;

   localparam int SLOTS = 2 + MAX_ROOMS;
   localparam int VW    = $clog2(MAX_VERTS);
   localparam int PW    = $clog2(SLOTS);
   localparam int DEPTH = SLOTS * MAX_VERTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_VERTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_POLY, S_RD_I, S_RD_J, S_CHECK, S_MUL2, S_WAIT1, S_CMP,
      S_NEXT, S_DONE
   } state_type;

   // vertex memory
   logic signed [31:0] mem_x [DEPTH];
   logic signed [31:0] mem_y [DEPTH];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;

   logic [CW-1:0]      sizes_ff [SLOTS];
   logic [3:0]         room_count_ff;
   logic signed [31:0] marker_ff;

   state_type          state_ff;
   req_type            req_ff;
   logic [PW-1:0]      poly_ff;
   logic [CW-1:0]      i_ff, j_ff;
   logic signed [31:0] xi_ff, yi_ff, xj_ff, yj_ff;
   logic               cross_ff;
   logic               box_ff, outline_ff;
   logic [7:0]         mask_ff;
   logic signed [65:0] p1_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   mul_req_type        mul_req;
   logic signed [65:0] product;

   pipmz_mul u_mul (.clock(clock), .mul_req(mul_req), .product(product));

   logic [CW-1:0] n_cur;
   logic [PW:0]   last_poly;
   logic [3:0]    rooms_eff;
   logic          y_gt_i, y_gt_j, hit, dy_pos;
   logic signed [32:0] dy;

   assign n_cur     = sizes_ff[poly_ff];
   assign rooms_eff = (32'(room_count_ff) > MAX_ROOMS) ? 4'(MAX_ROOMS) : room_count_ff;
   assign last_poly = (PW+1)'(rooms_eff) + (PW+1)'(1);
   assign y_gt_i    = yi_ff > req_ff.y_coord;
   assign y_gt_j    = yj_ff > req_ff.y_coord;
   assign dy        = 33'(yj_ff) - 33'(yi_ff);
   assign dy_pos    = dy > 0;
   // p1 = (x-xi)*dy, p2 = (xj-xi)*(y-yi)
   assign hit       = dy_pos ? (p1_ff < product) : (p1_ff > product);

   // operand select for the shared multiplier
   always_comb begin
      if (state_ff == S_CHECK) begin
         mul_req.a = 33'(req_ff.x_coord) - 33'(xi_ff);
         mul_req.b = dy;
      end else begin
         mul_req.a = 33'(xj_ff) - 33'(xi_ff);
         mul_req.b = 33'(req_ff.y_coord) - 33'(yi_ff);
      end
   end

   // memory address and write enable
   // vertex i is addressed in S_POLY or S_NEXT, before S_RD_J, vertex j during S_RD_J
   always_comb begin
      mem_we    = (state_ff == S_POLY) && (req_ff.op == OP_WRITE_VERTEX)
                  && (32'(req_ff.poly_index) < SLOTS)
                  && (32'(req_ff.vertex_index) < MAX_VERTS);
      mem_waddr = AW'(32'(req_ff.poly_index) * MAX_VERTS + 32'(req_ff.vertex_index));
      if (state_ff == S_POLY)
         mem_raddr = AW'(32'(poly_ff) * MAX_VERTS);
      else if (state_ff == S_NEXT)
         mem_raddr = AW'(32'(poly_ff) * MAX_VERTS + 32'(i_ff) + 1);
      else
         mem_raddr = AW'(32'(poly_ff) * MAX_VERTS + 32'(j_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[mem_waddr] <= req_ff.x_coord;
         mem_y[mem_waddr] <= req_ff.y_coord;
      end
      rd_x_ff <= mem_x[mem_raddr];
      rd_y_ff <= mem_y[mem_raddr];
   end

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= '0;
         marker_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROOM_COUNT:     room_count_ff <= csr_data[3:0];
            CSR_INVALID_MARKER: marker_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SLOTS; k++) sizes_ff[k] <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  poly_ff  <= '0;
                  i_ff     <= '0;
                  cross_ff <= 1'b0;
                  mask_ff  <= '0;
                  state_ff <= S_POLY;
               end
            end
            S_POLY: begin
               if (req_ff.op == OP_SET_COUNT) begin
                  if (32'(req_ff.poly_index) < SLOTS)
                     sizes_ff[PW'(req_ff.poly_index)] <=
                        (32'(req_ff.vertex_index) > MAX_VERTS) ? CW'(MAX_VERTS)
                                                             : CW'(req_ff.vertex_index);
                  state_ff <= S_IDLE;
               end else if (req_ff.op != OP_QUERY) begin
                  state_ff <= S_IDLE;
               end else if (32'(poly_ff) > 32'(last_poly)) begin
                  state_ff <= S_DONE;
               end else if (n_cur < CW'(3)) begin
                  cross_ff <= 1'b0;
                  state_ff <= S_NEXT;
               end else begin
                  i_ff     <= '0;
                  j_ff     <= n_cur - CW'(1);
                  cross_ff <= 1'b0;
                  state_ff <= S_RD_J;
               end
            end
            S_RD_J: begin
               // vertex i arrives
               xi_ff    <= rd_x_ff;
               yi_ff    <= rd_y_ff;
               state_ff <= S_RD_I;
            end
            S_RD_I: begin
               // vertex j arrives
               xj_ff    <= rd_x_ff;
               yj_ff    <= rd_y_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (y_gt_i == y_gt_j) state_ff <= S_NEXT;
               else state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p1_ff    <= product;
               state_ff <= S_WAIT1;
            end
            S_WAIT1: state_ff <= S_CMP;
            S_CMP: begin
               if (hit) cross_ff <= ~cross_ff;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (n_cur >= CW'(3) && (i_ff + CW'(1)) < n_cur) begin
                  j_ff     <= i_ff;
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_RD_J;
               end else begin
                  if (poly_ff == '0) box_ff <= cross_ff;
                  else if (32'(poly_ff) == 1) outline_ff <= cross_ff;
                  else if (32'(poly_ff) - 2 < 8)
                     mask_ff[3'(32'(poly_ff) - 2)] <= cross_ff;
                  poly_ff  <= poly_ff + PW'(1);
                  state_ff <= S_POLY;
               end
            end
            S_DONE: begin
               rsp_valid_ff        <= 1'b1;
               rsp_ff.inside_map   <= box_ff & outline_ff;
               rsp_ff.room_mask    <= mask_ff;
               rsp_ff.out_x <= (box_ff & outline_ff) ? req_ff.x_coord : marker_ff;
               rsp_ff.out_y <= (box_ff & outline_ff) ? req_ff.y_coord : marker_ff;
               rsp_ff.out_z <= (box_ff & outline_ff) ? req_ff.z_coord : marker_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

@@ src/pipmz_checker.sv @@
// ----------------------------------------------------------------------------
// pipmz_checker
// Port level checks for the polygon zone test block.
// ----------------------------------------------------------------------------
module pipmz_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input pipmz_pkg::rsp_type rsp_item
);
   import pipmz_pkg::*;

   // an accepted item makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after item");

   // result strobe lasts one cycle
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // result only after busy work
   a_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without item");

   // a point outside the map carries equal values (the marker) in all coordinates
   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.inside_map |->
         (rsp_item.out_x == rsp_item.out_y) && (rsp_item.out_y == rsp_item.out_z))
      else $error("marker not in all coordinates");
endmodule

bind point_in_polygon_map_zones pipmz_checker u_pipmz_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polygon zone block: loads polygons, sends
// query items and compares each result with a local crossing-rule predictor.
// ----------------------------------------------------------------------------
module tb;
   import pipmz_pkg::*;

   localparam int NV = 16;
   localparam int NSLOT = 10;
   localparam int QUIET_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type      req_item = '0;
   logic         rsp_valid;
   rsp_type      rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_data = '0;

   // predictor state
   logic signed [31:0] vert_x [NSLOT*NV];
   logic signed [31:0] vert_y [NSLOT*NV];
   int unsigned        poly_size [NSLOT];
   logic [3:0]         rooms_reg;
   logic signed [31:0] marker_reg;

   rsp_type     zone_queue [$];
   int          fail_count = 0;
   int          quiet = 0;
   int          queries = 0;
   int          loads = 0;
   int          hits = 0;

   always #5 clock = ~clock;

   point_in_polygon_map_zones DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // exact crossing test for one polygon
   function automatic bit point_in_poly(int unsigned p, longint x, longint y);
      int unsigned n;
      int unsigned j;
      longint xi, yi, xj, yj, dy;
      bit c;
      n = poly_size[p];
      c = 0;
      if (n < 3) return 0;
      j = n - 1;
      for (int unsigned i = 0; i < n; i++) begin
         xi = vert_x[p*NV+i];
         yi = vert_y[p*NV+i];
         xj = vert_x[p*NV+j];
         yj = vert_y[p*NV+j];
         if ((yi > y) != (yj > y)) begin
            dy = yj - yi;
            // 33 x 33 bit products fit in 128-bit signed arithmetic
            if (dy > 0) begin
               if ($signed(128'(x - xi)) * $signed(128'(dy))
                   < $signed(128'(xj - xi)) * $signed(128'(y - yi))) c = ~c;
            end else begin
               if ($signed(128'(x - xi)) * $signed(128'(dy))
                   > $signed(128'(xj - xi)) * $signed(128'(y - yi))) c = ~c;
            end
         end
         j = i;
      end
      return c;
   endfunction

   // update predictor state, queue the expected zone result for a query
   task automatic predict_zone(req_type r);
      rsp_type e;
      int unsigned nr;
      if (r.op == OP_WRITE_VERTEX) begin
         if (r.poly_index < NSLOT && r.vertex_index < NV) begin
            vert_x[r.poly_index*NV + r.vertex_index] = r.x_coord;
            vert_y[r.poly_index*NV + r.vertex_index] = r.y_coord;
         end
      end else if (r.op == OP_SET_COUNT) begin
         if (r.poly_index < NSLOT)
            poly_size[r.poly_index] = (r.vertex_index > NV) ? NV : r.vertex_index;
      end else if (r.op == OP_QUERY) begin
         nr = (rooms_reg > 8) ? 8 : rooms_reg;
         e.inside_map = point_in_poly(0, r.x_coord, r.y_coord)
                        && point_in_poly(1, r.x_coord, r.y_coord);
         e.room_mask = '0;
         for (int k = 0; k < nr; k++)
            e.room_mask[k] = point_in_poly(2 + k, r.x_coord, r.y_coord);
         e.out_x = e.inside_map ? r.x_coord : marker_reg;
         e.out_y = e.inside_map ? r.y_coord : marker_reg;
         e.out_z = e.inside_map ? r.z_coord : marker_reg;
         if (e.inside_map) hits++;
         zone_queue = {zone_queue, e};
         queries++;
      end
   endtask

   // send one item after a random gap; start stays high until the next gap
   task automatic send_item(req_type r);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_zone(r);
      if (r.op != OP_QUERY) loads++;
   endtask

   task automatic send_op(op_type op, int p, int v, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z);
      req_type r;
      r.op = op;
      r.poly_index = 4'(p);
      r.vertex_index = 5'(v);
      r.x_coord = x;
      r.y_coord = y;
      r.z_coord = z;
      send_item(r);
   endtask

   // wait for the block to drain before a register write
   task automatic wait_idle();
      start <= 1'b0;
      while (zone_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROOM_COUNT) rooms_reg = val[3:0];
      else marker_reg = val;
      @(posedge clock);
   endtask

   // load a polygon given as vertex lists
   task automatic load_poly(int p, logic signed [31:0] xs[$], logic signed [31:0] ys[$]);
      foreach (xs[i]) send_op(OP_WRITE_VERTEX, p, i, xs[i], ys[i], $urandom);
      send_op(OP_SET_COUNT, p, xs.size(), $urandom, $urandom, $urandom);
   endtask

   // random polygon around a centre, scale in Q16.16
   task automatic load_random_poly(int p, int n, int scale);
      logic signed [31:0] xs[$];
      logic signed [31:0] ys[$];
      int cx, cy;
      cx = $urandom_range(0, 2*scale) - scale;
      cy = $urandom_range(0, 2*scale) - scale;
      for (int i = 0; i < n; i++) begin
         xs = {xs, 32'(cx + int'($urandom_range(0, 2*scale)) - scale)};
         ys = {ys, 32'(cy + int'($urandom_range(0, 2*scale)) - scale)};
      end
      load_poly(p, xs, ys);
   endtask

   function automatic logic [31:0] rand_coord(int scale);
      longint span;
      span = 4 * longint'(scale) + 1;
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'(longint'($urandom) % span - 2 * longint'(scale));
   endfunction

   // directed: box, outline, rooms, extremes and ignored items
   task automatic test_directed();
      logic signed [31:0] xs[$];
      logic signed [31:0] ys[$];
      write_csr(CSR_ROOM_COUNT, 32'd2);
      write_csr(CSR_INVALID_MARKER, 32'h8000_0000);
      // box spanning the full range
      xs = {32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
      ys = {32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
      load_poly(0, xs, ys);
      // triangle outline
      xs = {-32'sd655360, 32'sd655360, 32'sd0};
      ys = {-32'sd655360, -32'sd655360, 32'sd655360};
      load_poly(1, xs, ys);
      load_random_poly(2, 3, 400000);
      // room in slot 3 degenerate: two vertices only
      xs = {32'sd0, 32'sd5};
      ys = {32'sd0, 32'sd5};
      load_poly(3, xs, ys);
      send_op(OP_QUERY, 0, 0, 0, 0, 32'h1234_5678);
      send_op(OP_QUERY, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
      send_op(OP_QUERY, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_op(OP_QUERY, 0, 0, 32'd655360, -32'sd655360, 32'd7);
      // bad slots, bad vertex index, oversized count, op three
      send_op(OP_WRITE_VERTEX, 15, 31, 32'hffff_ffff, 32'hffff_ffff, 0);
      send_op(OP_WRITE_VERTEX, 4, 16, 1, 1, 0);
      send_op(OP_SET_COUNT, 10, 31, 0, 0, 0);
      send_op(OP_NONE, 15, 31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_op(OP_QUERY, 1, 5, 32'd10, 32'd20, 32'd30);
   endtask

   // random loads of all polygons then many queries
   task automatic test_random_zones(int rounds);
      int scale;
      for (int r = 0; r < rounds; r++) begin
         scale = (r % 3 == 0) ? 1 << 30 : $urandom_range(1000, 2000000);
         wait_idle();
         write_csr(CSR_ROOM_COUNT, (r == 0) ? 32'd15 : 32'($urandom_range(0, 15)));
         write_csr(CSR_INVALID_MARKER, (r == 1) ? 32'h7fff_ffff : $urandom);
         for (int p = 0; p < NSLOT; p++)
            load_random_poly(p, (p == 4) ? NV : $urandom_range(3, 6), scale / 2);
         // oversized count saturates, keep vertices written
         if (r % 4 == 1) begin
            for (int v = 3; v < NV; v++) send_op(OP_WRITE_VERTEX, 5, v, $urandom, $urandom, 0);
            send_op(OP_SET_COUNT, 5, $urandom_range(17, 31), 0, 0, 0);
         end
         for (int q = 0; q < 18; q++)
            send_op(OP_QUERY, $urandom, $urandom, rand_coord(scale), rand_coord(scale),
                    $urandom);
         // noise that the block ignores
         send_op(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
         send_op(OP_WRITE_VERTEX, $urandom_range(10, 15), $urandom, $urandom, $urandom, 0);
      end
   endtask

   task automatic test_drain_pause();
      wait_idle();
      send_op(OP_QUERY, 0, 0, 0, 0, 0);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (zone_queue.size() == 0) begin
            $error("result with no expectation waiting");
            fail_count++;
         end else begin
            e = zone_queue.pop_front();
            if (rsp_item.inside_map !== e.inside_map) begin
               $error("inside_map exp %0d got %0d", e.inside_map, rsp_item.inside_map);
               fail_count++;
            end
            if (rsp_item.room_mask !== e.room_mask) begin
               $error("room_mask exp %h got %h", e.room_mask, rsp_item.room_mask);
               fail_count++;
            end
            if (rsp_item.out_x !== e.out_x) begin
               $error("out_x exp %h got %h", e.out_x, rsp_item.out_x);
               fail_count++;
            end
            if (rsp_item.out_y !== e.out_y) begin
               $error("out_y exp %h got %h", e.out_y, rsp_item.out_y);
               fail_count++;
            end
            if (rsp_item.out_z !== e.out_z) begin
               $error("out_z exp %h got %h", e.out_z, rsp_item.out_z);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted or returned
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      rooms_reg = '0;
      marker_reg = '0;
      foreach (poly_size[i]) poly_size[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random_zones(5);
      test_drain_pause();
      test_random_zones(2);
      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d queries and %0d load or ignored items, %0d inside the map",
               queries, loads, hits);
      if (fail_count == 0 && zone_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
